// File: rtl/fde_pkg.sv
// fde_pkg: shared constants for the feedback delay echo.
// Register indexes, reset values, Q1.15 constants and default sizes.
// No dependencies.
`default_nettype none

package fde_pkg;

    // Default sizes, used as parameter defaults by the top level and the output queue
    localparam int STORE_DEPTH_DEF = 131072;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int OUTQ_DEPTH      = 4;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_DELAY    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WET_MIX  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BYPASS   = 2'd3;

    // Register widths
    localparam int DELAY_W = 17;
    localparam int FB_W    = 15;
    localparam int WET_W   = 16;

    // Q1.15 arithmetic
    localparam int Q_SHIFT = 15;
    localparam int Q_HALF  = 16384;
    localparam logic [FB_W-1:0]  FB_CAP  = 15'd31130;
    localparam logic [WET_W:0]   MIX_ONE = 17'd32768;

    // Reset values
    localparam int DELAY_RESET = 48000;
    localparam logic [FB_W-1:0]  FB_RESET     = 15'd0;
    localparam logic [WET_W-1:0] WET_RESET    = 16'd16384;
    localparam logic             BYPASS_RESET = 1'b1;

endpackage

`default_nettype wire

// File: rtl/feedback_delay_echo.sv
// feedback_delay_echo: mono feedback echo with wet/dry mix on a ring memory.
// Depends on fde_pkg (constants) and fde_outq (output beat queue).
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: sample_in (signed)
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: sample_out (signed)
//  cfg       | in  | cfg_we (no wait, no readback) | cfg_index, cfg_data
//
// One sample per clock sustained while m_axis takes every beat. A beat passes
// accept/read address, memory data + feedback store and wet/dry sum in order.
// The rate is set by the single read and single write port of the ring memory
// and by the feedback loop, which closes through last_stored_reg.
// Reset takes effect at once: no clearing pass. Entries never written read as
// zero through a fill mark (write position plus a wrapped flag).
// Output stalls back up into a 4-beat queue; s_axis_tready drops only when
// the beats in flight would fill it.
`default_nettype none

module feedback_delay_echo #(
    parameter int STORE_DEPTH = fde_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = fde_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // stream in: [SAMPLE_BITS-1:0] sample_in, zero padded to bytes
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // stream out: [SAMPLE_BITS-1:0] sample_out, zero padded to bytes
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]           m_axis_tdata,
    // configuration write port
    input  wire logic                                  cfg_we,
    input  wire logic [fde_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [fde_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int TW  = ((SAMPLE_BITS+7)/8)*8;
    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int DW  = $clog2(STORE_DEPTH+1);
    localparam int CMW = (DW > fde_pkg::DELAY_W) ? DW : fde_pkg::DELAY_W;
    localparam int QD  = fde_pkg::OUTQ_DEPTH;
    localparam int QCW = $clog2(QD+1);
    localparam int QSH = fde_pkg::Q_SHIFT;

    localparam logic [DW-1:0]  DELAY_RST = DW'((fde_pkg::DELAY_RESET > STORE_DEPTH) ?
                                               STORE_DEPTH : fde_pkg::DELAY_RESET);
    localparam logic [CMW-1:0] DEPTH_CMP = CMW'(STORE_DEPTH);
    localparam logic [DW:0]    DEPTH_X   = (DW+1)'(STORE_DEPTH);
    localparam logic [AW-1:0]  POS_LAST  = AW'(STORE_DEPTH - 1);

    // ------------------------------------------------------------------
    // Configuration registers, clamped on write
    // ------------------------------------------------------------------
    logic [DW-1:0]                delay_reg;
    logic [fde_pkg::FB_W-1:0]     fb_reg;
    logic [fde_pkg::WET_W:0]      wet_reg;      // 0..32768
    logic                         bypass_reg;

    logic [CMW-1:0]               cfg_delay_x;
    logic [fde_pkg::FB_W-1:0]     cfg_fb;
    logic [fde_pkg::WET_W:0]      cfg_wet;

    assign cfg_delay_x = CMW'(cfg_data[fde_pkg::DELAY_W-1:0]);
    assign cfg_fb      = cfg_data[fde_pkg::FB_W-1:0];
    assign cfg_wet     = {1'b0, cfg_data[fde_pkg::WET_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= DELAY_RST;
            fb_reg     <= fde_pkg::FB_RESET;
            wet_reg    <= {1'b0, fde_pkg::WET_RESET};
            bypass_reg <= fde_pkg::BYPASS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fde_pkg::REG_DELAY:
                begin
                    if (cfg_delay_x == '0)
                        delay_reg <= DW'(1);
                    else if (cfg_delay_x > DEPTH_CMP)
                        delay_reg <= DW'(STORE_DEPTH);
                    else
                        delay_reg <= cfg_delay_x[DW-1:0];
                end
                fde_pkg::REG_FEEDBACK:
                begin
                    fb_reg <= (cfg_fb > fde_pkg::FB_CAP) ? fde_pkg::FB_CAP : cfg_fb;
                end
                fde_pkg::REG_WET_MIX:
                begin
                    wet_reg <= (cfg_wet > fde_pkg::MIX_ONE) ? fde_pkg::MIX_ONE : cfg_wet;
                end
                fde_pkg::REG_BYPASS:
                begin
                    bypass_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: ring position, read address, fill mark, forward check
    // ------------------------------------------------------------------
    logic               in_beat;
    logic [AW-1:0]      pos_reg, pos_next;
    logic               wrapped_reg, wrapped_next;
    logic [DW:0]        pos_x, delay_x, rd_wide;
    logic [AW-1:0]      rd_addr;
    logic               rd_written;
    logic               rd_fwd;

    // B stage: memory data returns, feedback sum is stored
    logic               b_valid_reg;
    logic               b_active_reg;
    logic [SB-1:0]      b_x_reg;
    logic [AW-1:0]      b_pos_reg;
    logic               b_fwd_reg;
    logic               b_written_reg;

    // C stage: wet/dry sum
    logic               c_valid_reg;
    logic               c_active_reg;
    logic [SB-1:0]      c_x_reg;
    logic signed [SB+17:0] c_dry_prod_reg;
    logic signed [SB+17:0] c_wet_prod_reg;

    logic [QCW-1:0]     q_count;
    logic [QCW:0]       occupancy;

    assign occupancy     = (QCW+1)'(q_count) + (QCW+1)'(b_valid_reg) + (QCW+1)'(c_valid_reg);
    assign s_axis_tready = (occupancy < (QCW+1)'(QD));
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // read address = pos - delay, modulo depth
    assign pos_x   = (DW+1)'(pos_reg);
    assign delay_x = {1'b0, delay_reg};
    assign rd_wide = (pos_x >= delay_x) ? (pos_x - delay_x) : (pos_x + DEPTH_X - delay_x);
    assign rd_addr = rd_wide[AW-1:0];

    // entries below the write position, or all after a wrap, hold real data
    assign rd_written = wrapped_reg || (rd_addr < pos_reg);
    // the beat ahead writes this entry in the same cycle as our read
    assign rd_fwd     = b_valid_reg && b_active_reg && (b_pos_reg == rd_addr);

    always_comb
    begin
        pos_next     = pos_reg;
        wrapped_next = wrapped_reg;
        if (in_beat && !bypass_reg)
        begin
            if (pos_reg == POS_LAST)
            begin
                pos_next     = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            wrapped_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            b_active_reg <= 1'b0;
            c_valid_reg  <= 1'b0;
            c_active_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            wrapped_reg  <= wrapped_next;
            b_valid_reg  <= in_beat;
            b_active_reg <= in_beat && !bypass_reg;
            c_valid_reg  <= b_valid_reg;
            c_active_reg <= b_active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            b_x_reg       <= s_axis_tdata[SB-1:0];
            b_pos_reg     <= pos_reg;
            b_fwd_reg     <= rd_fwd;
            b_written_reg <= rd_written;
        end
    end

    // ------------------------------------------------------------------
    // Ring memory: one read port (accept stage), one write port (B stage)
    // ------------------------------------------------------------------
    logic [SB-1:0] ring_mem [STORE_DEPTH];
    logic [SB-1:0] rd_data_reg;
    logic [SB-1:0] last_stored_reg;
    logic          mem_we;
    logic [SB-1:0] stored_sat;

    assign mem_we = b_valid_reg && b_active_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[b_pos_reg] <= stored_sat;
            last_stored_reg     <= stored_sat;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // B stage arithmetic
    // ------------------------------------------------------------------
    logic signed [SB-1:0]   delayed;
    logic signed [SB-1:0]   b_x_s;
    logic signed [15:0]     fb_s;
    logic signed [17:0]     dry_s, wet_s;
    logic [fde_pkg::WET_W:0] dry_gain;
    logic signed [SB+15:0]  fb_prod, fb_round;
    logic [SB:0]            fb_q;
    logic [SB+1:0]          stored_wide;

    assign delayed  = b_fwd_reg     ? $signed(last_stored_reg) :
                      b_written_reg ? $signed(rd_data_reg)     : '0;
    assign b_x_s    = $signed(b_x_reg);
    assign fb_s     = $signed({1'b0, fb_reg});
    assign dry_gain = fde_pkg::MIX_ONE - wet_reg;
    assign dry_s    = $signed({1'b0, dry_gain});
    assign wet_s    = $signed({1'b0, wet_reg});

    // feedback: x + round(delayed * fb), saturated
    assign fb_prod     = delayed * fb_s;
    assign fb_round    = fb_prod + (SB+16)'(fde_pkg::Q_HALF);
    assign fb_q        = fb_round[SB+15:QSH];
    assign stored_wide = {{2{b_x_reg[SB-1]}}, b_x_reg} + {fb_q[SB], fb_q};

    always_comb
    begin
        if ((&stored_wide[SB+1:SB-1]) || !(|stored_wide[SB+1:SB-1]))
            stored_sat = stored_wide[SB-1:0];
        else if (stored_wide[SB+1])
            stored_sat = {1'b1, {(SB-1){1'b0}}};
        else
            stored_sat = {1'b0, {(SB-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            c_x_reg        <= b_x_reg;
            c_dry_prod_reg <= b_x_s * dry_s;
            c_wet_prod_reg <= delayed * wet_s;
        end
    end

    // ------------------------------------------------------------------
    // C stage: round and saturate the mix, then queue
    // ------------------------------------------------------------------
    logic signed [SB+18:0] mix_sum;
    logic [SB+3:0]         mix_q;
    logic [SB-1:0]         mix_sat;
    logic [SB-1:0]         y;
    logic [SB-1:0]         q_data;

    assign mix_sum = {c_dry_prod_reg[SB+17], c_dry_prod_reg}
                   + {c_wet_prod_reg[SB+17], c_wet_prod_reg}
                   + (SB+19)'(fde_pkg::Q_HALF);
    assign mix_q   = mix_sum[SB+18:QSH];

    always_comb
    begin
        if ((&mix_q[SB+3:SB-1]) || !(|mix_q[SB+3:SB-1]))
            mix_sat = mix_q[SB-1:0];
        else if (mix_q[SB+3])
            mix_sat = {1'b1, {(SB-1){1'b0}}};
        else
            mix_sat = {1'b0, {(SB-1){1'b1}}};
    end

    assign y = c_active_reg ? mix_sat : c_x_reg;

    fde_outq #(
        .DEPTH (QD),
        .WIDTH (SB)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (c_valid_reg),
        .push_data (y),
        .tvalid    (m_axis_tvalid),
        .tready    (m_axis_tready),
        .tdata     (q_data),
        .count     (q_count)
    );

    assign m_axis_tdata = TW'(q_data);

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // beats in flight never exceed the queue room
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= (QCW+1)'(QD))
        else $error("in-flight beats exceed output queue");

    // forwarding only from an echo beat that wrote in the previous cycle
    a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_active_reg && b_fwd_reg) |-> $past(b_valid_reg && b_active_reg))
        else $error("forward without a preceding write");

    // clamped registers stay in range
    a_cfg_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fb_reg <= fde_pkg::FB_CAP) && (wet_reg <= fde_pkg::MIX_ONE) &&
        (delay_reg != '0) && (delay_reg <= DW'(STORE_DEPTH)))
        else $error("config register out of range");

    // C stage only fills from B
    a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> $past(b_valid_reg))
        else $error("C stage valid without B stage");

endmodule

`default_nettype wire

// File: rtl/fde_outq.sv
// fde_outq: small register queue that holds finished output beats.
// Uses fde_pkg for the default depth and width.
`default_nettype none

module fde_outq #(
    parameter int DEPTH = fde_pkg::OUTQ_DEPTH,
    parameter int WIDTH = fde_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire logic [WIDTH-1:0]             push_data,
    output logic                              tvalid,
    input  wire logic                         tready,
    output logic [WIDTH-1:0]                  tdata,
    output logic [$clog2(DEPTH+1)-1:0]        count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             pop;

    assign tvalid = (count_reg != '0);
    assign tdata  = slot_reg[rd_ptr_reg];
    assign count  = count_reg;
    assign pop    = tvalid && tready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // never more entries than slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("outq count above depth");

    // a push without a pop must find a free slot
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg < CW'(DEPTH)))
        else $error("outq overflow");

    // a lone pop drops the count by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("outq count did not drop on pop");

endmodule

`default_nettype wire

// File: dv/feedback_delay_echo_checker.sv
// feedback_delay_echo_checker: watches cfg writes and both stream channels of the echo,
// predicts each output sample from its own copy of the ring store and registers,
// and compares in order. Depends on fde_pkg.
`timescale 1ns / 100ps

module feedback_delay_echo_checker #(
    parameter int STORE_DEPTH = fde_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = fde_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    input  logic                                     s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         s_axis_tdata,
    input  logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_axis_tdata,
    input  logic                                     cfg_we,
    input  logic [fde_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  logic [fde_pkg::CFG_DATA_W-1:0]           cfg_data,
    output int                                       mismatches,
    output int                                       outstanding
);

    import fde_pkg::*;

    localparam int     SB           = SAMPLE_BITS;
    localparam int     REPORT_LIMIT = 10;
    localparam longint SAMPLE_MAX   = (longint'(1) << (SB - 1)) - 1;
    localparam longint SAMPLE_MIN   = -SAMPLE_MAX - 1;
    localparam longint WET_FULL     = longint'(MIX_ONE);

    // predictor state
    logic signed [SB-1:0] echo_mem [STORE_DEPTH];
    int unsigned          write_pos;
    logic [DELAY_W-1:0]   delay_reg;
    logic [FB_W-1:0]      fb_reg;
    logic [WET_W-1:0]     wet_reg;
    logic                 bypass_reg;

    logic [SB-1:0]        expected_samples [$];

    function automatic longint q15_round(input longint v);
        return (v + Q_HALF) >>> Q_SHIFT;
    endfunction

    function automatic longint clamp_sample(input longint v);
        if (v > SAMPLE_MAX)
            return SAMPLE_MAX;
        if (v < SAMPLE_MIN)
            return SAMPLE_MIN;
        return v;
    endfunction

    // one step of the echo: updates store and position unless bypassed
    function automatic logic [SB-1:0] echo_sample_out(input logic [SB-1:0] raw);
        longint      x;
        longint      delayed;
        longint      fb;
        longint      wm;
        longint      y;
        int unsigned d;
        int unsigned rd;
        if (bypass_reg)
            return raw;
        x  = longint'($signed(raw));
        d  = delay_reg;
        if (d == 0)
            d = 1;
        if (d > STORE_DEPTH)
            d = STORE_DEPTH;
        fb = (fb_reg > FB_CAP) ? FB_CAP : fb_reg;
        wm = (wet_reg > MIX_ONE) ? MIX_ONE : wet_reg;
        rd = (write_pos + STORE_DEPTH - d) % STORE_DEPTH;
        delayed = longint'(echo_mem[rd]);
        echo_mem[write_pos] = SB'(clamp_sample(x + q15_round(delayed * fb)));
        write_pos = (write_pos + 1) % STORE_DEPTH;
        y = clamp_sample(q15_round((WET_FULL - wm) * x + wm * delayed));
        return y[SB-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [SB-1:0] want;
        logic [SB-1:0] got;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
                echo_mem[i] = '0;
            write_pos  = 0;
            delay_reg  = DELAY_W'(DELAY_RESET);
            fb_reg     = FB_RESET;
            wet_reg    = WET_RESET;
            bypass_reg = BYPASS_RESET;
            expected_samples.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DELAY:    delay_reg  = cfg_data[DELAY_W-1:0];
                    REG_FEEDBACK: fb_reg     = cfg_data[FB_W-1:0];
                    REG_WET_MIX:  wet_reg    = cfg_data[WET_W-1:0];
                    REG_BYPASS:   bypass_reg = cfg_data[0];
                    default:      ;
                endcase
            end
            // output first: a result at this edge belongs to an older input
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[SB-1:0];
                if (expected_samples.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: sample_out %0d arrived with nothing pending",
                                 $time, $signed(got));
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: sample_out expected %0d, got %0d",
                                     $time, $signed(want), $signed(got));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_samples.push_back(echo_sample_out(s_axis_tdata[SB-1:0]));
            outstanding = expected_samples.size();
        end
    end

endmodule

// File: dv/feedback_delay_echo_test.sv
// feedback_delay_echo_test: stimulus and verdict for the feedback delay echo.
// Drives samples and register settings; feedback_delay_echo_checker predicts and compares.
// Depends on fde_pkg, feedback_delay_echo and feedback_delay_echo_checker.
`timescale 1ns / 100ps

module feedback_delay_echo_test;

    import fde_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int DW = ((SB + 7) / 8) * 8;

    // longest quiet stretch of a correct run stays below IDLE_LIMIT
    // (settle + 4 writes + sender gap + receiver stall + pipe)
    localparam int IDLE_LIMIT    = 1000;
    // pipe is 3 deep; give it some slack before touching registers
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1750;

    localparam logic [SB-1:0] SAMPLE_HI = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] SAMPLE_LO = {1'b1, {(SB-1){1'b0}}};

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DW-1:0]     s_axis_tdata;   // [SB-1:0] sample_in
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DW-1:0]     m_axis_tdata;   // [SB-1:0] sample_out
    logic              cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int outstanding;

    // sender burst bookkeeping
    int burst_left;
    int samples_sent;

    feedback_delay_echo dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    feedback_delay_echo_checker echo_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sender side. All tasks are entered and left at a falling edge.
    // ------------------------------------------------------------------

    // One beat on s_axis. Bursts of random length; between bursts valid
    // drops for a random gap. A zero gap merges bursts, so some stretches
    // run with no idling at all.
    task automatic send_sample(input logic [SB-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DW'(value);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        samples_sent++;
    endtask

    // Hold off until every predicted sample has come back, then let the
    // pipe settle so register writes land on an idle block.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Leaves cfg_we high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic program_echo(input logic [DELAY_W-1:0] delay,
                                input logic [FB_W-1:0] fb,
                                input logic [WET_W-1:0] wet,
                                input logic byp);
        write_reg(REG_DELAY, CFG_DATA_W'(delay));
        write_reg(REG_FEEDBACK, CFG_DATA_W'(fb));
        write_reg(REG_WET_MIX, CFG_DATA_W'(wet));
        write_reg(REG_BYPASS, CFG_DATA_W'(byp));
        cfg_we <= 1'b0;
    endtask

    // Mostly full-range noise, with rails and quiet samples mixed in so
    // both saturation and fine rounding get exercised.
    function automatic logic [SB-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? SAMPLE_HI : SAMPLE_LO;
            1:       return SB'($urandom_range(0, 511) - 256);
            2:       return $urandom_range(0, 1) ? SAMPLE_HI - SB'($urandom_range(0, 2047))
                                                 : SAMPLE_LO + SB'($urandom_range(0, 2047));
            default: return SB'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: its own stall pattern, changing at the end of each
    // random span between always ready, light and heavy random stalls, and
    // long periodic stalls that back the output queue up into s_axis.
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        int span;
        m_axis_tready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 200);
            for (int k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= ((k % 32) >= 20);
                endcase
            end
        end
    end

    // Watchdog: counts clocks in a row on which nothing moves on either stream
    // and ends the run once that count reaches IDLE_LIMIT.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("feedback_delay_echo_test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int                 n;
        int                 random_start;
        logic [DELAY_W-1:0] delay;
        logic [FB_W-1:0]    fb;
        logic [WET_W-1:0]   wet;
        logic               byp;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_DELAY;
        cfg_data      = '0;
        burst_left    = 0;
        samples_sent  = 0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed ---
        // reset state is bypass: rails and around zero pass straight through
        send_sample(SAMPLE_HI);
        send_sample(SAMPLE_LO);
        send_sample(SB'(0));
        send_sample('1);
        send_sample(SB'(1));

        // echo on with the other registers at reset: 48000-sample delay,
        // no feedback, half wet; the store still reads back zeros
        wait_drained();
        write_reg(REG_BYPASS, CFG_DATA_W'(1'b0));
        cfg_we <= 1'b0;
        send_sample(SAMPLE_HI);
        send_sample(SAMPLE_LO);
        send_sample(SB'(16'h1234));

        // zero delay acts as one; feedback and wet above their caps.
        // A run of rails pushes the stored sum into saturation.
        wait_drained();
        program_echo('0, '1, '1, 1'b0);
        repeat (4) send_sample(SAMPLE_HI);
        repeat (4) send_sample(SAMPLE_LO);

        // delay one, feedback at its cap, fully dry
        wait_drained();
        program_echo(DELAY_W'(1), FB_CAP, '0, 1'b0);
        send_sample(SAMPLE_HI);
        send_sample(SAMPLE_LO);
        send_sample(SB'(1));
        send_sample('1);

        // longest delay, fully wet: read address wraps around the end of the store
        wait_drained();
        program_echo('1, '0, WET_W'(MIX_ONE), 1'b0);
        send_sample(SAMPLE_HI);
        send_sample(SAMPLE_LO);

        // --- random phases ---
        // Each phase drains, picks new settings (edges weighted up) and
        // streams a random number of samples. Short delays dominate so the
        // echo and feedback actually come back within a phase; bypass
        // phases in between check that the store stays frozen.
        random_start = samples_sent;
        while (samples_sent - random_start < RANDOM_ITEMS)
        begin
            wait_drained();
            case ($urandom_range(0, 7))
                0:       delay = '0;
                1:       delay = DELAY_W'(1);
                2:       delay = '1;
                3:       delay = DELAY_W'($urandom_range(40000, 131071));
                default: delay = DELAY_W'($urandom_range(2, 64));
            endcase
            case ($urandom_range(0, 5))
                0:       fb = '0;
                1:       fb = FB_CAP;
                2:       fb = FB_W'($urandom_range(31131, 32767));
                default: fb = FB_W'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       wet = '0;
                1:       wet = WET_W'(MIX_ONE);
                2:       wet = WET_W'($urandom_range(32769, 65535));
                default: wet = WET_W'($urandom);
            endcase
            byp = ($urandom_range(0, 5) == 0);
            program_echo(delay, fb, wet, byp);

            n = $urandom_range(60, 180);
            for (int i = 0; i < n; i++)
            begin
                // now and then the sender waits for the block to run dry
                if (i == n / 2 && $urandom_range(0, 2) == 0)
                    wait_drained();
                send_sample(pick_sample());
            end
        end

        // --- wind down ---
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("feedback_delay_echo_test passed");
        else
            $display("feedback_delay_echo_test failed");
        $finish;
    end

endmodule

// File: files.f
rtl/fde_pkg.sv
rtl/fde_outq.sv
rtl/feedback_delay_echo.sv
dv/feedback_delay_echo_checker.sv
dv/feedback_delay_echo_test.sv
